### rtl/fwur_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fwur_pkg
// Types and constants shared by the firmware update receiver files.
// ----------------------------------------------------------------------------
package fwur_pkg;

    // Session phase; code 3 is unused and decodes as error
    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_RECV = 2'd1,
        PH_ERR  = 2'd2
    } t_phase;

    // Kind of incoming item
    typedef enum logic [1:0] {
        FUNC_START  = 2'd0,
        FUNC_DATA   = 2'd1,
        FUNC_FINISH = 2'd2,
        FUNC_TICK   = 2'd3
    } t_func;

    typedef enum logic [2:0] {
        RSP_START_ACK   = 3'd0,
        RSP_START_NACK  = 3'd1,
        RSP_DATA_ACK    = 3'd2,
        RSP_FINISH_ACK  = 3'd3,
        RSP_FINISH_NACK = 3'd4
    } t_rsp_kind;

    typedef enum logic [1:0] {
        NACK_NONE          = 2'd0,
        NACK_BAD_IMAGE     = 2'd1,
        NACK_ERASE_FAILED  = 2'd2,
        NACK_SIZE_MISMATCH = 2'd3
    } t_nack_reason;

    // Register map: index = paddr[3:2]
    localparam int PADDR_W = 4;
    typedef enum logic [1:0] {
        REG_OWN_ADDRESS      = 2'd0,
        REG_MAX_IMAGE_SIZE   = 2'd1,
        REG_INACTIVITY_LIMIT = 2'd2,
        REG_UNUSED           = 2'd3
    } t_reg_index;

    localparam logic [7:0]  OWN_ADDRESS_RST      = 8'd0;
    localparam logic [31:0] MAX_IMAGE_SIZE_RST   = 32'd1048576;
    localparam logic [15:0] INACTIVITY_LIMIT_RST = 16'd5000;

endpackage

### rtl/fwur_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fwur_req_if / fwur_rsp_if
// Valid/ready channels for incoming messages and outgoing responses.
// ----------------------------------------------------------------------------
interface fwur_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  func;
    logic [7:0]  dest_addr;
    logic [31:0] image_size;
    logic        version_ok;
    logic [31:0] staging_address;
    logic [31:0] sequence_number;
    logic [15:0] payload_length;
    logic        storage_ok;

    modport source (
        output valid, func, dest_addr, image_size, version_ok,
               staging_address, sequence_number, payload_length, storage_ok,
        input  ready
    );
    modport sink (
        input  valid, func, dest_addr, image_size, version_ok,
               staging_address, sequence_number, payload_length, storage_ok,
        output ready
    );
endinterface

interface fwur_rsp_if;
    logic        valid;
    logic        ready;
    logic [2:0]  response_kind;
    logic [1:0]  nack_reason;
    logic [31:0] acked_sequence;
    logic [31:0] chunk_address;
    logic        restart_request;

    modport source (
        output valid, response_kind, nack_reason, acked_sequence, chunk_address,
               restart_request,
        input  ready
    );
    modport sink (
        input  valid, response_kind, nack_reason, acked_sequence, chunk_address,
               restart_request,
        output ready
    );
endinterface

### rtl/firmware_update_receiver.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// firmware_update_receiver
// Receiving end of a firmware image transfer session.
// ----------------------------------------------------------------------------
// The block takes one message per cycle on i_req (start, data, finish or a
// tick) while its output register is free, and answers with at most one
// response on o_rsp in the cycle after the transfer. Each message is decoded
// combinationally against the session registers and the response lands in a
// one-deep output register; i_req stays ready as long as that register is
// empty or being drained, so a stalled response holds off only the following
// message. Ticks and ignored messages never occupy the output register.
// Phases: idle -> receiving on an accepted start, back to idle on a good
// finish, and a sticky error phase (erase or write failure, size mismatch,
// inactivity timeout) that only a reset clears. Registers on the APB port:
// 0x0 own_address, 0x4 max_image_size, 0x8 inactivity_limit (in ticks);
// write them only while the block is quiet. There is no reset sweep: the
// block is ready in the first cycle after reset.
// ----------------------------------------------------------------------------
module firmware_update_receiver (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    fwur_req_if.sink                      i_req,
    fwur_rsp_if.source                    o_rsp,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [fwur_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    // ---------------- configuration registers ----------------
    logic [7:0]  r_own_address;
    logic [31:0] r_max_image_size;
    logic [15:0] r_inactivity_limit;
    logic        cfg_wr;
    fwur_pkg::t_reg_index reg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign reg_idx = fwur_pkg::t_reg_index'(paddr[3:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_address      <= fwur_pkg::OWN_ADDRESS_RST;
            r_max_image_size   <= fwur_pkg::MAX_IMAGE_SIZE_RST;
            r_inactivity_limit <= fwur_pkg::INACTIVITY_LIMIT_RST;
        end else if (cfg_wr) begin
            case (reg_idx)
                fwur_pkg::REG_OWN_ADDRESS:      r_own_address      <= pwdata[7:0];
                fwur_pkg::REG_MAX_IMAGE_SIZE:   r_max_image_size   <= pwdata;
                fwur_pkg::REG_INACTIVITY_LIMIT: r_inactivity_limit <= pwdata[15:0];
                default: ;  // unmapped, write dropped
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            fwur_pkg::REG_OWN_ADDRESS:      prdata = {24'd0, r_own_address};
            fwur_pkg::REG_MAX_IMAGE_SIZE:   prdata = r_max_image_size;
            fwur_pkg::REG_INACTIVITY_LIMIT: prdata = {16'd0, r_inactivity_limit};
            default:                        prdata = 32'd0;
        endcase
    end

    // ---------------- session state ----------------
    fwur_pkg::t_phase r_phase, n_phase;
    logic [31:0] r_expected_sequence, n_expected_sequence;
    logic [31:0] r_write_address,     n_write_address;
    logic [31:0] r_bytes_received,    n_bytes_received;
    logic [31:0] r_announced_size,    n_announced_size;
    logic [15:0] r_idle_ticks,        n_idle_ticks;

    // ---------------- response register ----------------
    logic                      r_rsp_valid;
    fwur_pkg::t_rsp_kind       r_kind;
    fwur_pkg::t_nack_reason    r_reason;
    logic [31:0]               r_acked_sequence;
    logic [31:0]               r_chunk_address;
    logic                      r_restart;

    // Decode of the current message
    logic                      slot_free;
    logic                      accept;
    logic                      rsp_hit;       // message produces a response
    fwur_pkg::t_rsp_kind       rsp_kind;
    fwur_pkg::t_nack_reason    rsp_reason;
    logic [31:0]               rsp_seq;
    logic [31:0]               rsp_addr;
    logic                      rsp_restart;
    fwur_pkg::t_func           func;
    logic                      addr_match;
    logic [31:0]               len_ext;

    // Output slot frees when empty or when the sink takes it this cycle
    assign slot_free   = !r_rsp_valid || o_rsp.ready;
    assign i_req.ready = slot_free;
    assign accept      = i_req.valid && slot_free;

    assign func       = fwur_pkg::t_func'(i_req.func);
    assign addr_match = (i_req.dest_addr == r_own_address);
    assign len_ext    = {16'd0, i_req.payload_length};

    always_comb begin
        n_phase             = r_phase;
        n_expected_sequence = r_expected_sequence;
        n_write_address     = r_write_address;
        n_bytes_received    = r_bytes_received;
        n_announced_size    = r_announced_size;
        n_idle_ticks        = r_idle_ticks;
        rsp_hit             = 1'b0;
        rsp_kind            = fwur_pkg::RSP_START_ACK;
        rsp_reason          = fwur_pkg::NACK_NONE;
        rsp_seq             = 32'd0;
        rsp_addr            = 32'd0;
        rsp_restart         = 1'b0;

        if (func == fwur_pkg::FUNC_TICK) begin
            // Inactivity watchdog; counter saturates via the limit compare
            if (r_phase == fwur_pkg::PH_RECV) begin
                if (r_idle_ticks >= r_inactivity_limit) begin
                    n_phase = fwur_pkg::PH_ERR;
                end else begin
                    n_idle_ticks = r_idle_ticks + 16'd1;
                end
            end
        end else if (func == fwur_pkg::FUNC_START || addr_match) begin
            case (r_phase)
                fwur_pkg::PH_IDLE: begin
                    // Only a start addressed to us counts in idle
                    if (func == fwur_pkg::FUNC_START && addr_match) begin
                        n_announced_size = i_req.image_size;
                        rsp_hit          = 1'b1;
                        if (i_req.image_size > r_max_image_size ||
                            i_req.image_size == 32'd0 || !i_req.version_ok) begin
                            rsp_kind   = fwur_pkg::RSP_START_NACK;
                            rsp_reason = fwur_pkg::NACK_BAD_IMAGE;
                        end else if (!i_req.storage_ok) begin
                            n_phase    = fwur_pkg::PH_ERR;
                            rsp_kind   = fwur_pkg::RSP_START_NACK;
                            rsp_reason = fwur_pkg::NACK_ERASE_FAILED;
                        end else begin
                            n_expected_sequence = 32'd0;
                            n_bytes_received    = 32'd0;
                            n_write_address     = i_req.staging_address;
                            n_idle_ticks        = 16'd0;
                            n_phase             = fwur_pkg::PH_RECV;
                            rsp_kind            = fwur_pkg::RSP_START_ACK;
                        end
                    end
                end
                fwur_pkg::PH_RECV: begin
                    // Any message that passes the filter is activity
                    n_idle_ticks = 16'd0;
                    if (func == fwur_pkg::FUNC_DATA) begin
                        if (i_req.sequence_number == r_expected_sequence) begin
                            if (!i_req.storage_ok) begin
                                n_phase = fwur_pkg::PH_ERR;
                            end else begin
                                n_bytes_received    = r_bytes_received + len_ext;
                                n_write_address     = r_write_address + len_ext;
                                n_expected_sequence = r_expected_sequence + 32'd1;
                                rsp_hit             = 1'b1;
                                rsp_kind            = fwur_pkg::RSP_DATA_ACK;
                                rsp_seq             = i_req.sequence_number;
                                rsp_addr            = r_write_address;
                            end
                        end else if (i_req.sequence_number < r_expected_sequence) begin
                            // Duplicate: re-ack without an address
                            rsp_hit  = 1'b1;
                            rsp_kind = fwur_pkg::RSP_DATA_ACK;
                            rsp_seq  = i_req.sequence_number;
                        end
                    end else if (func == fwur_pkg::FUNC_FINISH) begin
                        rsp_hit = 1'b1;
                        if (r_bytes_received != r_announced_size) begin
                            n_phase    = fwur_pkg::PH_ERR;
                            rsp_kind   = fwur_pkg::RSP_FINISH_NACK;
                            rsp_reason = fwur_pkg::NACK_SIZE_MISMATCH;
                        end else begin
                            n_phase     = fwur_pkg::PH_IDLE;
                            rsp_kind    = fwur_pkg::RSP_FINISH_ACK;
                            rsp_restart = 1'b1;
                        end
                    end
                end
                default: ;  // error phase (and unused code) is sticky
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase             <= fwur_pkg::PH_IDLE;
            r_expected_sequence <= 32'd0;
            r_write_address     <= 32'd0;
            r_bytes_received    <= 32'd0;
            r_announced_size    <= 32'd0;
            r_idle_ticks        <= 16'd0;
        end else if (accept) begin
            r_phase             <= n_phase;
            r_expected_sequence <= n_expected_sequence;
            r_write_address     <= n_write_address;
            r_bytes_received    <= n_bytes_received;
            r_announced_size    <= n_announced_size;
            r_idle_ticks        <= n_idle_ticks;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rsp_valid <= 1'b0;
        end else if (slot_free) begin
            r_rsp_valid <= accept && rsp_hit;
        end
    end

    // Payload needs no reset; loaded only with a new response
    always_ff @(posedge i_clk) begin
        if (accept && rsp_hit) begin
            r_kind           <= rsp_kind;
            r_reason         <= rsp_reason;
            r_acked_sequence <= rsp_seq;
            r_chunk_address  <= rsp_addr;
            r_restart        <= rsp_restart;
        end
    end

    assign o_rsp.valid           = r_rsp_valid;
    assign o_rsp.response_kind   = r_kind;
    assign o_rsp.nack_reason     = r_reason;
    assign o_rsp.acked_sequence  = r_acked_sequence;
    assign o_rsp.chunk_address   = r_chunk_address;
    assign o_rsp.restart_request = r_restart;

endmodule

### rtl/fwur_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fwur_checker
// Port-level checks for the firmware update receiver, bound to the top level.
// ----------------------------------------------------------------------------
module fwur_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_req_valid,
    input logic        i_req_ready,
    input logic        i_rsp_valid,
    input logic        i_rsp_ready,
    input logic [2:0]  i_rsp_kind,
    input logic [1:0]  i_rsp_reason,
    input logic [31:0] i_rsp_seq,
    input logic [31:0] i_rsp_addr,
    input logic        i_rsp_restart
);

    // No response right after reset
    a_rst_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_rsp_valid)
        else $error("response valid after reset");

    // Stalled response holds
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid && $stable(i_rsp_kind)
            && $stable(i_rsp_reason) && $stable(i_rsp_seq) && $stable(i_rsp_addr)
            && $stable(i_rsp_restart))
        else $error("stalled response changed");

    // Full output register blocks new messages
    a_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |-> !(i_req_valid && i_req_ready))
        else $error("message taken while response stalled");

    // Restart only with a finish ack
    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_rsp_restart |->
            i_rsp_kind == fwur_pkg::RSP_FINISH_ACK)
        else $error("restart outside finish ack");

    // A reason only on a NACK
    a_reason: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_rsp_reason != fwur_pkg::NACK_NONE |->
            i_rsp_kind == fwur_pkg::RSP_START_NACK ||
            i_rsp_kind == fwur_pkg::RSP_FINISH_NACK)
        else $error("nack reason on a non-nack response");

endmodule

bind firmware_update_receiver fwur_checker u_fwur_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_req_valid   (i_req.valid),
    .i_req_ready   (i_req.ready),
    .i_rsp_valid   (o_rsp.valid),
    .i_rsp_ready   (o_rsp.ready),
    .i_rsp_kind    (o_rsp.response_kind),
    .i_rsp_reason  (o_rsp.nack_reason),
    .i_rsp_seq     (o_rsp.acked_sequence),
    .i_rsp_addr    (o_rsp.chunk_address),
    .i_rsp_restart (o_rsp.restart_request)
);
